/* sv/threshold_cascade_closure_top_macros.svh */
// Assertion macros shared by the threshold cascade RTL.
`ifndef THRESHOLD_CASCADE_CLOSURE_TOP_MACROS_SVH
`define THRESHOLD_CASCADE_CLOSURE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/tcc_pkg.sv */
// Package with the widths, codes and helper functions of the threshold cascade block.
package tcc_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned VERT_AW      = $clog2(MAX_VERTICES);
  localparam int unsigned VERTEX_W     = 6;
  localparam int unsigned ROW_W        = 64;
  localparam int unsigned THR_W        = 7;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned RAM_W        = ROW_W + THR_W;
  localparam int unsigned BYTE_N       = ROW_W / 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_FINISH
  } state_e;

  // Bit i is set for every vertex i below n.
  function automatic logic [ROW_W-1:0] active_mask(input logic [CFG_W-1:0] n);
    logic [ROW_W-1:0] m;
    for (int i = 0; i < ROW_W; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

/* sv/tcc_if.sv */
// Request and result channel interfaces of the threshold cascade block.
interface tcc_in_if import tcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [VERTEX_W-1:0] vertex;
  logic [ROW_W-1:0]    neighbours;
  logic [THR_W-1:0]    threshold;
  logic [ROW_W-1:0]    immune_set;

  modport source(output valid, operation, vertex, neighbours, threshold, immune_set,
                 input ready);
  modport sink(input valid, operation, vertex, neighbours, threshold, immune_set,
               output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] influenced_set;
  logic [CNT_W-1:0] influenced_count;

  modport source(output valid, influenced_set, influenced_count, input ready);
  modport sink(input valid, influenced_set, influenced_count, output ready);
endinterface

/* sv/tcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tcc_popcmp.sv */
// Shared unit: counts influenced neighbours of one row and compares with its threshold.
module tcc_popcmp import tcc_pkg::*; (
  input  logic [ROW_W-1:0] row_i,
  input  logic [ROW_W-1:0] mask_i,
  input  logic [THR_W-1:0] thr_i,
  output logic             reach_o
);

  logic [ROW_W-1:0] masked;
  logic [3:0]       byte_cnt [BYTE_N];
  logic [CNT_W-1:0] total;

  // Bytes are counted independently, then the eight partial counts are summed.
  always_comb begin
    masked = row_i & mask_i;
    total  = '0;
    for (int b = 0; b < BYTE_N; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(masked[8*b+k]);
      end
    end
    for (int b = 0; b < BYTE_N; b++) begin
      total = total + CNT_W'(byte_cnt[b]);
    end
  end

  assign reach_o = (total >= CNT_W'(thr_i));

endmodule

/* sv/threshold_cascade_closure_top.sv */
// Top level of the threshold cascade block: request decode, sweep sequencer, result register.
// Requests arrive on in_ch. A load request (operation 0) writes one vertex's adjacency row
// and threshold into the vertex store and produces no result. A run request (operation 1)
// carries an immune set and yields exactly one result on out_ch: the closed influenced set
// and its population count.
// A run sweeps the vertices in use one per cycle through a single popcount-and-compare
// unit fed by the registered read port of the vertex store. Sweeps repeat until one
// changes nothing, so a run makes at most n + 1 sweeps over n vertices; a run with no
// vertex in use skips the sweep and goes straight to its result.
// in_ch.ready is low while a run is in progress and high otherwise.
// The result sits in an output register; a stalled receiver does not block load requests,
// but a following run holds its result, and the request channel, until the register frees.
// Reset (rst_ni, asynchronous, active low) sets vertex_count to 64 and clears the control
// state. The vertex store is not cleared: every vertex in use must be loaded before a run.
// The user writes vertex_count only while the block is idle; the block does not enforce it.
`include "threshold_cascade_closure_top_macros.svh"

module threshold_cascade_closure_top import tcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tcc_in_if.sink           in_ch,
  tcc_out_if.source        out_ch
);

  state_e             state_q, state_d;
  logic [VERT_AW-1:0] ptr_q, ptr_d;
  logic [VERT_AW-1:0] last_q, last_d;
  logic [VERT_AW-1:0] ridx_q, ridx_d;
  logic               rvld_q, rvld_d;
  logic               changed_q, changed_d;
  logic [ROW_W-1:0]   elig_q, elig_d;
  logic [ROW_W-1:0]   infl_q, infl_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CFG_W-1:0]   vcount_q;
  logic               out_valid_q, out_valid_d;
  logic [ROW_W-1:0]   out_set_q;
  logic [CNT_W-1:0]   out_cnt_q;
  logic               out_load;

  logic [CFG_W-1:0]   n_eff;
  logic               ram_we;
  logic [RAM_W-1:0]   ram_rdata;
  logic               reach;
  logic               hit;

  // Vertices beyond the store depth are never in use.
  assign n_eff = (vcount_q > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_q;

  // Adjacency row in the low bits, threshold above it.
  tcc_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_ch.vertex[VERT_AW-1:0]),
    .wdata_i({in_ch.threshold, in_ch.neighbours}),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  tcc_popcmp u_popcmp (
    .row_i  (ram_rdata[ROW_W-1:0]),
    .mask_i (infl_q),
    .thr_i  (ram_rdata[RAM_W-1:ROW_W]),
    .reach_o(reach)
  );

  // A vertex joins when its row is back, eligible, not yet in, and its threshold is reached.
  assign hit = rvld_q && elig_q[ridx_q] && !infl_q[ridx_q] && reach;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    ridx_d      = ridx_q;
    rvld_d      = 1'b0;
    changed_d   = changed_q;
    elig_d      = elig_q;
    infl_d      = infl_q;
    cnt_d       = cnt_q;
    ram_we      = 1'b0;
    out_load    = 1'b0;
    in_ch.ready = 1'b0;

    if (hit) begin
      infl_d    = infl_q | (ROW_W'(1) << ridx_q);
      cnt_d     = cnt_q + CNT_W'(1);
      changed_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (op_e'(in_ch.operation) == OP_LOAD) begin
            ram_we = (32'(in_ch.vertex) < MAX_VERTICES);
          end else begin
            elig_d    = active_mask(n_eff) & ~in_ch.immune_set;
            infl_d    = '0;
            cnt_d     = '0;
            ptr_d     = '0;
            last_d    = VERT_AW'(n_eff - CFG_W'(1));
            changed_d = 1'b0;
            state_d   = (n_eff == '0) ? S_FINISH : S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        rvld_d = 1'b1;
        ridx_d = ptr_q;
        if (ptr_q == last_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = ptr_q + VERT_AW'(1);
        end
      end
      S_DRAIN: begin
        // The last row of the sweep is evaluated here; any change calls for another sweep.
        if (changed_q || hit) begin
          state_d   = S_SWEEP;
          ptr_d     = '0;
          changed_d = 1'b0;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ch.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rvld_q      <= 1'b0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
      vcount_q    <= CFG_W'(64);
      infl_q      <= '0;
      cnt_q       <= '0;
      elig_q      <= '0;
    end else begin
      state_q     <= state_d;
      rvld_q      <= rvld_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
      infl_q      <= infl_d;
      cnt_q       <= cnt_d;
      elig_q      <= elig_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    last_q <= last_d;
    ridx_q <= ridx_d;
    if (out_load) begin
      out_set_q <= infl_q;
      out_cnt_q <= cnt_q;
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.influenced_set   = out_set_q;
  assign out_ch.influenced_count = out_cnt_q;

  `TCC_ASSERT_NOW(a_count_tracks_set, 1'b1, cnt_q == CNT_W'($countones(infl_q)), "influenced count out of step with the set")
  `TCC_ASSERT_NOW(a_set_within_eligible, 1'b1, (infl_q & ~elig_q) == '0, "immune or unused vertex influenced")
  `TCC_ASSERT_NOW(a_store_write_idle, ram_we, state_q == S_IDLE, "vertex store written during a run")
  `TCC_ASSERT_NEXT(a_set_grows, (state_q == S_SWEEP) || (state_q == S_DRAIN), (infl_q & $past(infl_q)) == $past(infl_q), "influenced vertex dropped during a run")

endmodule

/* dv/tcc_closure_checker.sv */
// Checker that predicts the closed influenced set of every run request and compares results.
`timescale 1ns / 1ps

module tcc_closure_checker import tcc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  tcc_in_if                in_mon,
  tcc_out_if               out_mon,
  output int unsigned      errors_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [ROW_W-1:0] vertices;
    logic [CNT_W-1:0] population;
  } closure_t;

  logic [ROW_W-1:0] row_store [MAX_VERTICES];
  logic [THR_W-1:0] threshold_store [MAX_VERTICES];
  logic [CFG_W-1:0] vertex_count;
  closure_t         closures_due [$];

  // Vertices are visited in ascending order and a newly influenced vertex counts at once
  // for the ones after it in the same sweep.
  function automatic closure_t cascade_closure(input logic [ROW_W-1:0] immune);
    closure_t         result;
    int               n;
    logic [ROW_W-1:0] eligible;
    logic [ROW_W-1:0] grown;
    logic [ROW_W-1:0] prev;
    n = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    eligible = '0;
    for (int u = 0; u < n; u++) eligible[u] = 1'b1;
    eligible &= ~immune;
    grown = '0;
    for (int u = 0; u < n; u++) begin
      if (eligible[u] && threshold_store[u] == '0) grown[u] = 1'b1;
    end
    do begin
      prev = grown;
      for (int u = 0; u < n; u++) begin
        if (eligible[u] && $countones(row_store[u] & grown) >= int'(threshold_store[u])) begin
          grown[u] = 1'b1;
        end
      end
    end while (grown != prev);
    result.vertices   = grown;
    result.population = CNT_W'($countones(grown));
    return result;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    closure_t want;
    if (!rst_ni) begin
      vertex_count = CFG_W'(MAX_VERTICES);
      closures_due.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) vertex_count = cfg_wdata_i;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_LOAD) begin
          row_store[in_mon.vertex]       = in_mon.neighbours;
          threshold_store[in_mon.vertex] = in_mon.threshold;
        end else begin
          closures_due.insert(closures_due.size(), cascade_closure(in_mon.immune_set));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (closures_due.size() == 0) begin
          $display("%0t: result with nothing expected: set %h count %0d", $time,
                   out_mon.influenced_set, out_mon.influenced_count);
          errors_o++;
        end else begin
          want = closures_due.pop_front();
          if (out_mon.influenced_set !== want.vertices) begin
            $display("%0t: influenced_set expected %h actual %h", $time,
                     want.vertices, out_mon.influenced_set);
            errors_o++;
          end
          if (out_mon.influenced_count !== want.population) begin
            $display("%0t: influenced_count expected %0d actual %0d", $time,
                     want.population, out_mon.influenced_count);
            errors_o++;
          end
        end
      end
      pending_o = closures_due.size();
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top: clock, reset, request and result traffic, vertex count phases, verdict.
`timescale 1ns / 1ps

module tb import tcc_pkg::*; ();

  // A run over 64 vertices makes at most 65 sweeps. Roughly 1900 requests of that worst kind
  // set the scale; the limit sits several times above it.
  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  // A load is written once it is taken; this margin is plenty before touching the register.
  localparam int unsigned SETTLE_CYCLES = 16;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  int unsigned      errors;
  int unsigned      pending;
  int unsigned      cycle_count;

  // Stimulus-side view of the store: a run may only read vertices loaded since reset.
  logic [ROW_W-1:0] written;
  int               count_setting;
  logic             send_calm;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();

  threshold_cascade_closure_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  tcc_closure_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Watchdog: a run that never drains ends here as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [ROW_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Rows of varied density, so that cascades both stall early and sweep the whole graph.
  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = random_word();
    b = random_word();
    c = random_word();
    case ($urandom_range(0, 7))
      0:       return a & b & c;
      1, 2:    return a & b;
      3, 4:    return a;
      5:       return a | b;
      6:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return ROW_W'(1) << $urandom_range(0, ROW_W - 1);
    endcase
  endfunction

  // Mostly small thresholds that can be met, some that sit exactly at the degree, and
  // a tail up to the field maximum that is never reached.
  function automatic logic [THR_W-1:0] random_threshold(input logic [ROW_W-1:0] row);
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3, 4: return THR_W'($urandom_range(1, 2));
      5, 6:    return THR_W'($urandom_range(1, 6));
      7:       return THR_W'($urandom_range(0, 40));
      8:       return THR_W'($urandom_range(0, 127));
      default: return ($urandom_range(0, 1) != 0) ? '1 : THR_W'($countones(row));
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] random_immune();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5, 6:    return random_word() & random_word() & random_word();
      7:          return random_word() & random_word();
      8:          return random_word();
      default:    return ($urandom_range(0, 1) != 0) ? '1 : ROW_W'(1) << $urandom_range(0, 63);
    endcase
  endfunction

  // Present one request and hold it until the block takes it. The sender idles a random
  // number of cycles first, except during calm stretches where requests go back to back.
  task automatic send_request(input op_e op, input logic [VERTEX_W-1:0] v,
                              input logic [ROW_W-1:0] row, input logic [THR_W-1:0] thr,
                              input logic [ROW_W-1:0] immune);
    int gap;
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.operation  = op;
    in_ch.vertex     = v;
    in_ch.neighbours = row;
    in_ch.threshold  = thr;
    in_ch.immune_set = immune;
    in_ch.valid      = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Fields that an operation does not use carry random noise.
  task automatic load_vertex(input int v, input logic [ROW_W-1:0] row,
                             input logic [THR_W-1:0] thr);
    send_request(OP_LOAD, VERTEX_W'(v), row, thr, random_word());
    written[v] = 1'b1;
  endtask

  task automatic run_cascade(input logic [ROW_W-1:0] immune);
    send_request(OP_RUN, VERTEX_W'($urandom), random_word(), THR_W'($urandom), immune);
  endtask

  // Stop sending, let every expected result arrive and the store settle.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_vertex_count(input int n);
    wait_idle();
    cfg_wdata_i = CFG_W'(n);
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    count_setting = n;
  endtask

  // One phase of random traffic at the current vertex count. Any vertex in use that was
  // never loaded gets loaded before the next run, so no run reads an unwritten entry.
  // Now and then a descending chain is loaded: each vertex waits on the next one up, so
  // the cascade climbs down one vertex per sweep and the run takes the most sweeps.
  task automatic run_phase(input int items);
    int               in_use;
    int               v;
    logic [ROW_W-1:0] need;
    logic [ROW_W-1:0] missing;
    logic [ROW_W-1:0] row;
    in_use = (count_setting > MAX_VERTICES) ? MAX_VERTICES : count_setting;
    need = '0;
    for (int i = 0; i < in_use; i++) need[i] = 1'b1;
    for (int item = 0; item < items; item++) begin
      missing = need & ~written;
      if (missing != '0) begin
        v = 0;
        while (!missing[v]) v++;
        row = random_row();
        load_vertex(v, row, random_threshold(row));
      end else if (in_use > 1 && $urandom_range(0, 79) == 0) begin
        for (int i = 0; i < in_use; i++) begin
          if (i == in_use - 1) load_vertex(i, random_row(), '0);
          else load_vertex(i, ROW_W'(1) << (i + 1), THR_W'(1));
        end
        run_cascade($urandom_range(0, 3) == 0 ? ROW_W'(1) << $urandom_range(0, 63) : '0);
        item += in_use;
      end else if ($urandom_range(0, 9) < 4) begin
        if (in_use > 0 && $urandom_range(0, 9) < 7) v = $urandom_range(0, in_use - 1);
        else v = $urandom_range(0, MAX_VERTICES - 1);
        row = random_row();
        load_vertex(v, row, random_threshold(row));
      end else begin
        run_cascade(random_immune());
      end
    end
  endtask

  // Result side: the receiver stalls a random number of cycles before each result, with
  // calm stretches of its own where it accepts at once.
  initial begin : receiver
    int   stall;
    logic recv_calm;
    recv_calm    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int phase_counts [10];
    phase_counts = '{64, 1, 2, 127, 0, 65, 33, 3, 64, 17};
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_LOAD;
    in_ch.vertex     = '0;
    in_ch.neighbours = '0;
    in_ch.threshold  = '0;
    in_ch.immune_set = '0;
    written          = '0;
    send_calm        = 1'b0;
    count_setting    = MAX_VERTICES;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // With no vertex in use a run touches no entry of the store and returns an empty set.
    set_vertex_count(0);
    run_cascade('0);
    run_cascade('1);

    // Four vertices: a seed with threshold zero, a follower of the seed, a vertex whose
    // threshold is out of reach, and one that only sees itself.
    set_vertex_count(4);
    load_vertex(0, '0, '0);
    load_vertex(1, ROW_W'(1), THR_W'(1));
    load_vertex(2, '1, '1);
    load_vertex(3, ROW_W'(1) << 3, THR_W'(1));
    run_cascade('0);
    run_cascade('1);
    run_cascade(ROW_W'(1));
    run_cascade(ROW_W'(1) << 63);
    // Row bits pointing past the vertices in use must not add to the count.
    load_vertex(2, '1, THR_W'(2));
    run_cascade('0);
    // A self edge counts, but cannot lift a vertex on its own.
    load_vertex(3, (ROW_W'(1) << 3) | ROW_W'(1), THR_W'(2));
    run_cascade('0);
    load_vertex(1, '1, THR_W'(4));
    load_vertex(0, '1, '0);
    load_vertex(63, '1, '1);
    run_cascade(ROW_W'(1) << 2);
    run_cascade('0);

    foreach (phase_counts[p]) begin
      set_vertex_count(phase_counts[p]);
      run_phase(135);
    end
    repeat (4) begin
      set_vertex_count($urandom_range(1, MAX_VERTICES));
      run_phase(120);
    end

    wait_idle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/tcc_pkg.sv
sv/tcc_if.sv
sv/tcc_ram.sv
sv/tcc_popcmp.sv
sv/threshold_cascade_closure_top.sv
dv/tcc_closure_checker.sv
dv/tb.sv
